[src/cbb_pkg.sv]
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared constants and types for the clamped box blur.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 8;
  localparam int CH_BITS    = 16;
  localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RING_W = $clog2(RING_ROWS);
  localparam int ADDR_W = RING_W + COL_W;
  localparam int PIX_W  = 3 * CH_BITS;
  localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W  = CH_BITS + CNT_W;
  localparam int POS_W  = 27;
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CH_BITS-1:0] chan_t;

endpackage

[src/cbb_store.sv]
// ----------------------------------------------------------------------------
// cbb_store
// Ring of pixel rows: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cbb_store (
  input  logic                    clk,
  input  logic                    we,
  input  logic [cbb_pkg::ADDR_W-1:0] waddr,
  input  logic [cbb_pkg::PIX_W-1:0]  wdata,
  input  logic [cbb_pkg::ADDR_W-1:0] raddr,
  output logic [cbb_pkg::PIX_W-1:0]  rdata
);
  import cbb_pkg::*;

  logic [PIX_W-1:0] mem [RING_ROWS * MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/cbb_div.sv]
// ----------------------------------------------------------------------------
// cbb_div
// Three restoring dividers sharing one control, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbb_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  cbb_pkg::sum_t           dividend [3],
  input  logic [cbb_pkg::CNT_W-1:0] divisor,
  output logic                    done,
  output cbb_pkg::chan_t          quotient [3]
);
  import cbb_pkg::*;

  logic [SUM_W-1:0]  q [3];
  logic [CNT_W-1:0]  rem [3];
  logic [CNT_W-1:0]  dv;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [CNT_W:0]    trial [3];
  logic              fits [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], q[i][SUM_W-1]};
      fits[i]  = trial[i] >= {1'b0, dv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv <= divisor;
      for (int i = 0; i < 3; i++) begin
        q[i]   <= dividend[i];
        rem[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < 3; i++) begin
        rem[i] <= fits[i] ? CNT_W'(trial[i] - {1'b0, dv}) : trial[i][CNT_W-1:0];
        q[i]   <= {q[i][SUM_W-2:0], fits[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quotient[i] = q[i][CH_BITS-1:0];
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held two cycles");
  a_nonzero: assert property (@(posedge clk) disable iff (rst) busy |-> dv != '0)
    else $error("divide by zero");
`endif

endmodule

[src/clamped_box_blur_rgb.sv]
// ----------------------------------------------------------------------------
// clamped_box_blur_rgb
// Box blur over an RGB raster stream with the window clipped at the edges.
// ----------------------------------------------------------------------------
// Sequence: a pixel that yields no output is taken in ST_IDLE alone; one that
//   yields an output passes ST_SCAN, which reads the clipped window (up to
//   289 pixels) one per cycle, then ST_DRAIN, ST_DIV and the ST_OUT handshake.
// Throughput: one transaction at a time; the single read port of the row
//   store and the bit-serial divider set the rate.
// Reset: synchronous, clears positions and control; registers take defaults.
module clamped_box_blur_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [9:0]  out_column,
  output logic [15:0] out_row,
  output logic        frame_last
);
  import cbb_pkg::*;

  // configuration, already clamped to the legal range
  logic [10:0] width;
  logic [15:0] height;
  logic [3:0]  radius;

  state_t state, state_next;

  // input side position
  logic [POS_W-1:0]  in_pos;
  logic [COL_W-1:0]  in_col;
  logic [RING_W-1:0] in_ring;
  // output side position
  logic [POS_W-1:0]  out_pos;
  logic [COL_W-1:0]  o_col;
  logic [15:0]       o_row;
  logic [RING_W-1:0] o_ring;

  // window scan
  logic [RING_W-1:0] scan_ring;
  logic [COL_W-1:0]  scan_col, scan_col0;
  logic [SPAN_W-1:0] cols_left, rows_left, ncols;
  logic [CNT_W-1:0]  win_count;
  logic              rd_v;
  sum_t              sums [3];

  logic [POS_W-1:0] total, lag;
  logic             accept, out_take, is_last, scan_end;

  logic [PIX_W-1:0]  rdata, wdata;
  logic [ADDR_W-1:0] raddr;

  logic       div_done;
  chan_t      quot [3];

  // window bounds for the current output pixel
  logic [4:0]        up, down, left, right;
  logic [15:0]       below;
  logic [10:0]       after;
  logic [SPAN_W-1:0] nrows_w, ncols_w;
  logic [RING_W:0]   ring_sum;
  logic [RING_W-1:0] ring0;

  assign total = POS_W'(width) * POS_W'(height);
  assign lag   = POS_W'(radius) * POS_W'(width) + POS_W'(radius);

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign is_last  = (out_pos + 1'b1) >= total;
  assign scan_end = (cols_left == '0) && (rows_left == '0);

  always_comb begin
    below = height - 16'd1 - o_row;
    after = width - 11'd1 - 11'(o_col);
    up    = (o_row >= 16'(radius)) ? 5'(radius) : 5'(o_row);
    down  = (below >= 16'(radius)) ? 5'(radius) : 5'(below);
    left  = (11'(o_col) >= 11'(radius)) ? 5'(radius) : 5'(o_col);
    right = (after >= 11'(radius)) ? 5'(radius) : 5'(after);
    nrows_w = SPAN_W'(up + down + 5'd1);
    ncols_w = SPAN_W'(left + right + 5'd1);
    // step back "up" rows around the ring
    ring_sum = (o_ring >= RING_W'(up)) ? ((RING_W+1)'(o_ring) - (RING_W+1)'(up))
             : ((RING_W+1)'(o_ring) + (RING_W+1)'(RING_ROWS) - (RING_W+1)'(up));
    ring0 = ring_sum[RING_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept && in_pos >= lag) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last read word has been added in
        if (!rd_v) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration and positions
  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= 11'd1024;
      height  <= 16'd1024;
      radius  <= 4'd2;
      in_pos  <= '0;
      in_col  <= '0;
      in_ring <= '0;
      out_pos <= '0;
      o_col   <= '0;
      o_row   <= '0;
      o_ring  <= '0;
    end else if (cfg_write && cfg_index <= CFG_RADIUS) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          width <= (cfg_data[10:0] == '0) ? 11'd1 :
                   (cfg_data[10:0] > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg_data[10:0];
        end
        CFG_HEIGHT: begin
          height <= (cfg_data == '0) ? 16'd1 : cfg_data;
        end
        CFG_RADIUS: begin
          radius <= (cfg_data[3:0] == '0) ? 4'd1 :
                    (cfg_data[3:0] > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : cfg_data[3:0];
        end
        default: ;
      endcase
      // restart the frame
      in_pos  <= '0;
      in_col  <= '0;
      in_ring <= '0;
      out_pos <= '0;
      o_col   <= '0;
      o_row   <= '0;
      o_ring  <= '0;
    end else if (out_take && is_last) begin
      // frame done: next transaction is pixel zero
      in_pos  <= '0;
      in_col  <= '0;
      in_ring <= '0;
      out_pos <= '0;
      o_col   <= '0;
      o_row   <= '0;
      o_ring  <= '0;
    end else begin
      if (accept) begin
        in_pos <= in_pos + 1'b1;
        if (11'(in_col) == width - 11'd1) begin
          in_col  <= '0;
          in_ring <= (in_ring == RING_W'(RING_ROWS - 1)) ? '0 : in_ring + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (out_take) begin
        out_pos <= out_pos + 1'b1;
        if (11'(o_col) == width - 11'd1) begin
          o_col  <= '0;
          o_row  <= o_row + 1'b1;
          o_ring <= (o_ring == RING_W'(RING_ROWS - 1)) ? '0 : o_ring + 1'b1;
        end else begin
          o_col <= o_col + 1'b1;
        end
      end
    end
  end

  // scan the clipped window, one pixel per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_ring <= ring0;
      scan_col0 <= o_col - COL_W'(left);
      scan_col  <= o_col - COL_W'(left);
      ncols     <= ncols_w;
      cols_left <= ncols_w - 1'b1;
      rows_left <= nrows_w - 1'b1;
      win_count <= CNT_W'(nrows_w) * CNT_W'(ncols_w);
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (state == ST_SCAN && !scan_end) begin
        if (cols_left == '0) begin
          rows_left <= rows_left - 1'b1;
          cols_left <= ncols - 1'b1;
          scan_col  <= scan_col0;
          scan_ring <= (scan_ring == RING_W'(RING_ROWS - 1)) ? '0 : scan_ring + 1'b1;
        end else begin
          cols_left <= cols_left - 1'b1;
          scan_col  <= scan_col + 1'b1;
        end
      end
      if (rd_v) begin
        for (int i = 0; i < 3; i++) begin
          sums[i] <= sums[i] + SUM_W'(rdata[i*CH_BITS +: CH_BITS]);
        end
      end
    end
  end

  // drain transactions write zero
  assign wdata = mode ? '0 : {in_blue, in_green, in_red};
  assign raddr = {scan_ring, scan_col};

  cbb_store u_store (
    .clk   (clk),
    .we    (accept && in_pos < total),
    .waddr ({in_ring, in_col}),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  cbb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DRAIN && !rd_v),
    .dividend (sums),
    .divisor  (win_count),
    .done     (div_done),
    .quotient (quot)
  );

  assign out_red    = quot[0];
  assign out_green  = quot[1];
  assign out_blue   = quot[2];
  assign out_column = o_col;
  assign out_row    = o_row;
  assign frame_last = is_last;

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(out_valid && !in_stall))
    else $error("input open while a result waits");
  a_read_scan: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("read data outside the window scan");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_red) && $stable(out_row)))
    else $error("stalled result changed");
`endif

endmodule

[tb/clamped_box_blur_rgb_tb.sv]
// ----------------------------------------------------------------------------
// clamped_box_blur_rgb_tb
// Streams frames of RGB pixels through the box blur and checks every output
// pixel against a behavioral window-mean model, under random idling on both
// sides and across several width, height and radius settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clamped_box_blur_rgb_tb;
  import cbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [9:0]  out_column;
  logic [15:0] out_row;
  logic        frame_last;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [9:0]  column;
    logic [15:0] row;
    logic        last;
  } blur_pixel_t;

  // Expected output pixels, oldest first.
  blur_pixel_t blurred_queue[$];

  // Model state: ring of rows, active settings and frame positions.
  logic [47:0] ring_pixels [RING_ROWS*MAX_WIDTH];
  int unsigned img_w, img_h, rad;
  int unsigned pos_in, pos_out;

  int error_count;
  int sender_idle_pct;
  int receiver_idle_pct;
  int idle_cycles;

  clamped_box_blur_rgb u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_column (out_column),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clip_setting(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the model by one accepted transaction; queue an output if one is due.
  function automatic void predict_blur(logic is_drain, logic [15:0] r, logic [15:0] g,
                                       logic [15:0] b);
    int unsigned total, lag, p, k, row, col, r0, r1, c0, c1, cnt;
    longint unsigned sr, sg, sb;
    logic [47:0] px;
    blur_pixel_t e;
    total = img_w * img_h;
    lag = rad * img_w + rad;
    p = pos_in;
    if (p < total) begin
      px = is_drain ? 48'd0 : {b, g, r};
      ring_pixels[((p / img_w) % RING_ROWS) * MAX_WIDTH + (p % img_w)] = px;
    end
    pos_in = p + 1;
    if (p < lag) return;
    k = pos_out;
    row = k / img_w;
    col = k % img_w;
    r0 = (row >= rad) ? row - rad : 0;
    r1 = (row + rad <= img_h - 1) ? row + rad : img_h - 1;
    c0 = (col >= rad) ? col - rad : 0;
    c1 = (col + rad <= img_w - 1) ? col + rad : img_w - 1;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned y = r0; y <= r1; y++) begin
      for (int unsigned x = c0; x <= c1; x++) begin
        px = ring_pixels[(y % RING_ROWS) * MAX_WIDTH + x];
        sr += px[15:0];
        sg += px[31:16];
        sb += px[47:32];
      end
    end
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    e.red = 16'(sr / cnt);
    e.green = 16'(sg / cnt);
    e.blue = 16'(sb / cnt);
    e.column = 10'(col);
    e.row = 16'(row);
    e.last = (k + 1 >= total);
    blurred_queue.push_back(e);
    pos_out = k + 1;
    if (e.last) begin
      pos_in = 0;
      pos_out = 0;
    end
  endfunction

  // Write one register; the block must be idle.
  task automatic write_setting(logic [1:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_WIDTH:  img_w = clip_setting(value & 16'h7FF, MAX_WIDTH);
      CFG_HEIGHT: img_h = clip_setting(value, 65535);
      CFG_RADIUS: rad = clip_setting(value & 16'hF, MAX_RADIUS);
      default: return;
    endcase
    pos_in = 0;
    pos_out = 0;
  endtask

  // Send one transaction, with a random idle gap ahead of it; valid stays
  // high after the handshake until the next gap or the next drop.
  task automatic send_pixel(logic is_drain, logic [15:0] r, logic [15:0] g,
                            logic [15:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= is_drain;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_blur(is_drain, r, g, b);
  endtask

  // Drop valid, hold until every expected output has arrived, then settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (blurred_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_channel();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one whole frame plus its drain tail; noise_pct mixes in odd items.
  task automatic send_frame(int noise_pct);
    int unsigned total, lag;
    logic dr;
    total = img_w * img_h;
    lag = rad * img_w + rad;
    for (int unsigned i = 0; i < total + lag; i++) begin
      dr = (i >= total);
      if ($urandom_range(99) < noise_pct) dr = ~dr;
      send_pixel(dr, rand_channel(), rand_channel(), rand_channel());
    end
    wait_idle();
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned r);
    write_setting(CFG_WIDTH, 16'(w));
    write_setting(CFG_HEIGHT, 16'(h));
    write_setting(CFG_RADIUS, 16'(r));
  endtask

  // Directed: extreme channels, drain in a pixel slot, pixel in a drain slot.
  task automatic test_directed();
    configure(3, 3, 1);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b0, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'hFFFF, 16'h1234, 16'h5678);
    send_pixel(1'b0, 16'h8000, 16'h0001, 16'hFFFE);
    send_pixel(1'b0, 16'h00FF, 16'hFF00, 16'hAAAA);
    send_pixel(1'b0, 16'h5555, 16'hFFFF, 16'h0000);
    send_pixel(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_pixel(1'b0, 16'h0001, 16'h7FFF, 16'h8001);
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b0, 16'h1111, 16'h2222, 16'h3333);
    repeat (3) send_pixel(1'b1, 16'h0, 16'h0, 16'h0);
    wait_idle();
    // Out-of-range register index is ignored.
    write_setting(2'd3, 16'h0005);
    // Zero settings clip up to one.
    configure(0, 0, 0);
    send_frame(0);
    // Over-range width and radius clip down.
    configure(16'h7FF, 2, 15);
    img_w = MAX_WIDTH;
    configure(2, 2, 8);
    send_frame(0);
  endtask

  // Random frames at small sizes, with a few wide and tall ones; the budget
  // counts pixel and drain transactions alike.
  task automatic test_random_frames(int unsigned item_budget);
    int unsigned sent;
    sent = 0;
    while (sent < item_budget) begin
      case ($urandom_range(9))
        0: configure($urandom_range(64, 160), 1, $urandom_range(1, 2));
        1: configure(1, $urandom_range(1, 40), $urandom_range(1, MAX_RADIUS));
        default: configure($urandom_range(1, 12), $urandom_range(1, 10),
                           $urandom_range(1, MAX_RADIUS));
      endcase
      sent += img_w * img_h + rad * img_w + rad;
      send_frame(($urandom_range(3) == 0) ? 10 : 0);
    end
  endtask

  // Compare each output transaction with the oldest expectation.
  initial begin
    blur_pixel_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (blurred_queue.size() == 0) begin
          $error("output with none expected: row %0d column %0d", out_row, out_column);
          error_count++;
        end else begin
          e = blurred_queue.pop_front();
          if (out_red !== e.red) begin
            $error("out_red expected %h actual %h", e.red, out_red); error_count++;
          end
          if (out_green !== e.green) begin
            $error("out_green expected %h actual %h", e.green, out_green); error_count++;
          end
          if (out_blue !== e.blue) begin
            $error("out_blue expected %h actual %h", e.blue, out_blue); error_count++;
          end
          if (out_column !== e.column) begin
            $error("out_column expected %0d actual %0d", e.column, out_column);
            error_count++;
          end
          if (out_row !== e.row) begin
            $error("out_row expected %0d actual %0d", e.row, out_row); error_count++;
          end
          if (frame_last !== e.last) begin
            $error("frame_last expected %0b actual %0b", e.last, frame_last);
            error_count++;
          end
        end
      end
    end
  end

  // Drive receiver stall at random.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // End the run if nothing moves for too long.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    error_count = 0;
    idle_cycles = 0;
    sender_idle_pct = 22;
    receiver_idle_pct = 71;
    img_w = 1024;
    img_h = 1024;
    rad = 2;
    pos_in = 0;
    pos_out = 0;
    foreach (ring_pixels[i]) ring_pixels[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_frames(520);
    sender_idle_pct = 71;
    receiver_idle_pct = 22;
    test_random_frames(520);
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_frames(520);

    wait_idle();
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
